// File: rtl/aprs_pkg.sv
// ============================================================================
// APRS-IS header parser package
// Shared types, character codes, field limits and phase codes.
// ============================================================================
package aprs_pkg;

  // Number of path elements before the next element is taken as q construct.
  localparam int unsigned MaxPath = 6;
  localparam int unsigned IdxW    = $clog2(MaxPath + 1);

  // Characters that steer the header grammar.
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChGreater = 8'h3E;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChLowerQ  = 8'h71;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChZero    = 8'h30;

  // Name length limits; a name byte at or beyond its limit is flagged as overflow.
  localparam logic [7:0] LimSrc  = 8'd10;
  localparam logic [7:0] LimDest = 8'd7;
  localparam logic [7:0] LimCall = 8'd10;
  localparam logic [7:0] LimQ    = 8'd3;
  localparam logic [7:0] LimOrig = 8'd11;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_SRC       = 4'd1,
    PH_SRC_SSID  = 4'd2,
    PH_DEST      = 4'd3,
    PH_PATH      = 4'd4,
    PH_PATH_SSID = 4'd5,
    PH_QCON      = 4'd6,
    PH_ORIG      = 4'd7,
    PH_ORIG_SSID = 4'd8,
    PH_SKIP      = 4'd9,
    PH_PAYLOAD   = 4'd10,
    PH_COMMENT   = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    FK_SKIP    = 3'd0,
    FK_SOURCE  = 3'd1,
    FK_DEST    = 3'd2,
    FK_PATH    = 3'd3,
    FK_QCON    = 3'd4,
    FK_ORIG    = 3'd5,
    FK_PAYLOAD = 3'd6,
    FK_COMMENT = 3'd7
  } field_kind_e;

  typedef enum logic [1:0] {
    LS_BUSY      = 2'd0,
    LS_OK        = 2'd1,
    LS_COMMENT   = 2'd2,
    LS_MALFORMED = 2'd3
  } line_status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0] field_kind;
    logic [2:0] path_slot;
    logic [7:0] char_pos;
    logic [7:0] char_out;
    logic       ssid_valid;
    logic [6:0] ssid_value;
    logic       name_overflow;
    logic [1:0] line_status;
    logic [2:0] path_count;
    logic       line_end;
  } out_item_t;

  typedef struct packed {
    phase_e          phase;
    logic [IdxW-1:0] idx;
    logic [7:0]      pos;
    logic [6:0]      acc;
    logic [1:0]      cnt;
    logic            seen;
  } parse_state_t;

  localparam parse_state_t StateClear = '{
    phase: PH_START, idx: '0, pos: '0, acc: '0, cnt: '0, seen: 1'b0
  };

  function automatic line_status_e status_of(phase_e ph);
    line_status_e s;
    case (ph)
      PH_PAYLOAD: s = LS_OK;
      PH_COMMENT: s = LS_COMMENT;
      default:    s = LS_MALFORMED;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/aprs_if.sv
// ============================================================================
// APRS-IS header parser channels
// Valid/ready channels for input bytes and tagged results.
// ============================================================================
interface aprs_in_if;
  logic               valid;
  logic               ready;
  aprs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aprs_out_if;
  logic                valid;
  logic                ready;
  aprs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/aprs_is_header_parser.sv
// ============================================================================
// APRS-IS header parser
// Tags each byte of an APRS-IS text line with its header field in one pass.
// ============================================================================
// Timing: each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register frees in the same cycle
// it is taken, so a byte is accepted whenever the result slot is empty or
// being drained. The parse state update is the only loop and closes per byte.
// Reset: asynchronous, active low; clears the parse state to line start and
// empties the result register.
module aprs_is_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  aprs_in_if.sink           in_i,
  aprs_out_if.source        out_o
);
  import aprs_pkg::*;

  // Parse state registers and the result register.
  parse_state_t st_q, st_d, st_nxt;
  out_item_t    res_q, res_d;
  logic         res_valid_q, res_valid_d;

  logic         in_fire;
  logic [7:0]   b;
  logic         eob;
  logic         is_end;
  logic         is_digit;
  logic [3:0]   digit;
  phase_e       eff_phase;
  logic [7:0]   pos_inc;
  logic [IdxW-1:0] idx_inc;
  phase_e       path_next;

  // The result slot accepts a new request when empty or when it is drained in
  // this very cycle, so bytes stream at one per cycle under a ready sink.
  assign in_i.ready  = !res_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  assign b   = in_i.data.byte_value;
  assign eob = in_i.data.end_of_buffer;

  // A NUL or newline byte ends the line on its own and is never tagged.
  assign is_end = (b == ChNul) || (b == ChNewline);

  always_comb begin
    is_digit = b inside {[8'h30:8'h39]};
  end
  assign digit = 4'(b - ChZero);

  // The first byte of a line chooses between comment and normal header, and
  // is then handled by the chosen phase in the same cycle.
  assign eff_phase = (st_q.phase == PH_START) ?
                     ((b == ChHash) ? PH_COMMENT : PH_SRC) : st_q.phase;

  // Position counts saturate at 255.
  assign pos_inc = (st_q.pos == 8'hFF) ? st_q.pos : st_q.pos + 8'd1;

  // Closing a path element advances the slot up to the path limit; once the
  // limit is reached the next element is taken as the q construct.
  assign idx_inc   = (32'(st_q.idx) < MaxPath) ? st_q.idx + IdxW'(1) : st_q.idx;
  assign path_next = (32'(idx_inc) >= MaxPath) ? PH_QCON : PH_PATH;

  // Next parse state for a non-terminating byte, before any line end.
  always_comb begin
    parse_state_t cl;
    cl       = st_q;
    cl.pos   = '0;
    cl.acc   = '0;
    cl.cnt   = '0;
    cl.seen  = 1'b0;
    st_nxt       = st_q;
    st_nxt.phase = eff_phase;
    case (eff_phase)
      PH_SRC: begin
        if (b == ChGreater) begin
          st_nxt = cl; st_nxt.phase = PH_DEST;
        end else if (b == ChDash) begin
          st_nxt.seen = 1'b1; st_nxt.phase = PH_SRC_SSID;
        end else begin
          st_nxt.pos = pos_inc;
        end
      end
      PH_DEST: begin
        if (b == ChComma) begin
          st_nxt = cl; st_nxt.idx = '0; st_nxt.phase = PH_PATH;
        end else if (b == ChColon) begin
          st_nxt = cl; st_nxt.phase = PH_PAYLOAD;
        end else begin
          st_nxt.pos = pos_inc;
        end
      end
      PH_PATH: begin
        if (b == ChComma) begin
          st_nxt = cl; st_nxt.idx = idx_inc; st_nxt.phase = path_next;
        end else if (b == ChColon) begin
          st_nxt = cl; st_nxt.idx = idx_inc; st_nxt.phase = PH_PAYLOAD;
        end else if (b == ChDash) begin
          st_nxt.seen = 1'b1; st_nxt.phase = PH_PATH_SSID;
        end else if (b == ChLowerQ && st_q.pos == 8'd0) begin
          st_nxt.pos = pos_inc; st_nxt.phase = PH_QCON;
        end else begin
          st_nxt.pos = pos_inc;
        end
      end
      PH_QCON: begin
        if (b == ChComma) begin
          st_nxt = cl; st_nxt.phase = PH_ORIG;
        end else if (b == ChColon) begin
          st_nxt = cl; st_nxt.phase = PH_PAYLOAD;
        end else begin
          st_nxt.pos = pos_inc;
        end
      end
      PH_ORIG: begin
        if (b == ChColon) begin
          st_nxt = cl; st_nxt.phase = PH_PAYLOAD;
        end else if (b == ChComma) begin
          st_nxt = cl; st_nxt.phase = PH_SKIP;
        end else if (b == ChDash) begin
          st_nxt.seen = 1'b1; st_nxt.phase = PH_ORIG_SSID;
        end else begin
          st_nxt.pos = pos_inc;
        end
      end
      PH_SRC_SSID, PH_PATH_SSID, PH_ORIG_SSID: begin
        // The closing separator depends on which element carries the SSID.
        if (eff_phase == PH_SRC_SSID && b == ChGreater) begin
          st_nxt = cl; st_nxt.phase = PH_DEST;
        end else if (eff_phase == PH_PATH_SSID && b == ChComma) begin
          st_nxt = cl; st_nxt.idx = idx_inc; st_nxt.phase = path_next;
        end else if (eff_phase == PH_PATH_SSID && b == ChColon) begin
          st_nxt = cl; st_nxt.idx = idx_inc; st_nxt.phase = PH_PAYLOAD;
        end else if (eff_phase == PH_ORIG_SSID && b == ChColon) begin
          st_nxt = cl; st_nxt.phase = PH_PAYLOAD;
        end else if (eff_phase == PH_ORIG_SSID && b == ChComma) begin
          st_nxt = cl; st_nxt.phase = PH_SKIP;
        end else if (st_q.cnt < 2'd2 && is_digit) begin
          // At most two digits; the accumulator is at most 9 before the
          // second one, so the product fits in seven bits.
          st_nxt.acc = 7'((st_q.acc << 3) + (st_q.acc << 1) + 7'(digit));
          st_nxt.cnt = st_q.cnt + 2'd1;
        end else begin
          st_nxt.cnt = 2'd3;
        end
      end
      PH_SKIP: begin
        if (b == ChColon) begin
          st_nxt.pos = '0; st_nxt.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD, PH_COMMENT: begin
        st_nxt.pos = pos_inc;
      end
      default: begin
        st_nxt = StateClear;
      end
    endcase
  end

  // Any line end, by terminator byte or by end of buffer, returns to line start.
  assign st_d = (is_end || eob) ? StateClear : st_nxt;

  // Result fields for the byte.
  always_comb begin
    logic closes;
    logic [IdxW-1:0] pc_idx;
    closes = 1'b0;
    res_d = '0;
    res_d.char_out = b;
    if (is_end) begin
      res_d.line_end    = 1'b1;
      res_d.line_status = status_of(st_q.phase);
    end else begin
      case (eff_phase)
        PH_SRC: begin
          if (b == ChGreater) begin
            closes = 1'b1;
          end else if (b != ChDash) begin
            res_d.field_kind    = FK_SOURCE;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimSrc);
          end
        end
        PH_DEST: begin
          if (b == ChComma || b == ChColon) begin
            closes = 1'b1;
          end else begin
            res_d.field_kind    = FK_DEST;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimDest);
          end
        end
        PH_PATH: begin
          res_d.path_slot = 3'(st_q.idx);
          if (b == ChComma || b == ChColon) begin
            closes = 1'b1;
          end else if (b == ChLowerQ && st_q.pos == 8'd0) begin
            // A leading q turns the element into the q construct.
            res_d.path_slot     = '0;
            res_d.field_kind    = FK_QCON;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimQ);
          end else if (b != ChDash) begin
            res_d.field_kind    = FK_PATH;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimCall);
          end
        end
        PH_PATH_SSID: begin
          res_d.path_slot = 3'(st_q.idx);
          closes = (b == ChComma) || (b == ChColon);
        end
        PH_SRC_SSID: closes = (b == ChGreater);
        PH_ORIG_SSID: closes = (b == ChComma) || (b == ChColon);
        PH_QCON: begin
          if (b == ChComma || b == ChColon) begin
            closes = 1'b1;
          end else begin
            res_d.field_kind    = FK_QCON;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimQ);
          end
        end
        PH_ORIG: begin
          if (b == ChComma || b == ChColon) begin
            closes = 1'b1;
          end else if (b != ChDash) begin
            res_d.field_kind    = FK_ORIG;
            res_d.char_pos      = st_q.pos;
            res_d.name_overflow = (st_q.pos >= LimOrig);
          end
        end
        PH_PAYLOAD: begin
          res_d.field_kind = FK_PAYLOAD;
          res_d.char_pos   = st_q.pos;
        end
        PH_COMMENT: begin
          res_d.field_kind = FK_COMMENT;
          res_d.char_pos   = st_q.pos;
        end
        default: begin
          res_d.field_kind = FK_SKIP;
        end
      endcase
      if (closes && st_q.seen) begin
        res_d.ssid_valid = 1'b1;
        res_d.ssid_value = st_q.acc;
      end
      if (eob) begin
        res_d.line_end    = 1'b1;
        res_d.line_status = status_of(st_nxt.phase);
      end
    end
    // The path count is reported on the line end only, saturating at seven.
    pc_idx = is_end ? st_q.idx : st_nxt.idx;
    if (res_d.line_end) begin
      res_d.path_count = (32'(pc_idx) > 7) ? 3'd7 : 3'(pc_idx);
    end
  end

  assign res_valid_d = in_fire ? 1'b1 : (out_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateClear;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (in_fire) begin
        st_q <= st_d;
      end
    end
  end

  // The result payload carries no reset; it is qualified by its valid bit.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  // A byte that ends a line leaves the parser at line start.
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_d.line_end |=> st_q.phase == PH_START && st_q.idx == '0)
    else $error("parse state not cleared after line end");

  // The path slot never runs past the path limit.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(st_q.idx) <= MaxPath)
    else $error("path slot beyond limit");

  // An SSID is only reported on a separator and never above two digits.
  a_ssid_on_separator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.ssid_valid |->
      out_o.data.field_kind == FK_SKIP && out_o.data.ssid_value <= 7'd99)
    else $error("SSID reported on a non-separator byte");

  // The path count and line status are only shown on the last result of a line.
  a_count_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.line_end |-> out_o.data.path_count == 3'd0 &&
      out_o.data.line_status == LS_BUSY)
    else $error("line summary shown before line end");
`endif

endmodule
